// ===== rtl/bresenham_ellipse_raster_core_assert.svh =====
// ----------------------------------------------------------------------------
// Ellipse rasterizer assertion macros
// Shared macros for the concurrent checks of the ellipse rasterizer.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_ELLIPSE_RASTER_CORE_ASSERT_SVH
`define BRESENHAM_ELLIPSE_RASTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define BERA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ellipse rasterizer check failed");

// Next-cycle implication, checked outside of reset.
`define BERA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ellipse rasterizer check failed");

`endif

// ===== rtl/bera_pkg.sv =====
// ----------------------------------------------------------------------------
// Ellipse rasterizer package
// Types and fixed widths shared by the front queue and the step engine.
// ----------------------------------------------------------------------------
package bera_pkg;

  localparam int ACC_W   = 48;
  localparam int COORD_W = 12;
  localparam int QDEPTH  = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOOP = 2'd1,
    PH_TIP  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    BS_IDLE   = 3'd0,
    BS_SETUP1 = 3'd1,
    BS_SETUP2 = 3'd2,
    BS_RUN    = 3'd3
  } bstate_t;

  typedef struct packed {
    op_t         op;
    logic [9:0]  center_x;
    logic [9:0]  center_y;
    logic [8:0]  x_half;
    logic [8:0]  y_half;
    logic [31:0] pen_color;
  } item_t;

endpackage

// ===== rtl/bera_front.sv =====
// ----------------------------------------------------------------------------
// Ellipse rasterizer front queue
// Accepts commands, decodes them and buffers them for the step engine.
// ----------------------------------------------------------------------------
module bera_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                cmd,
  input  logic [9:0]          center_x,
  input  logic [9:0]          center_y,
  input  logic [9:0]          x_diameter,
  input  logic [9:0]          y_diameter,
  input  logic [31:0]         pen_color,
  output logic                q_valid,
  output bera_pkg::item_t     q_item,
  input  logic                q_pop
);

  localparam int PTR_W = $clog2(bera_pkg::QDEPTH);

  bera_pkg::item_t  mem [bera_pkg::QDEPTH];
  bera_pkg::item_t  in_item;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    in_item.op        = cmd ? bera_pkg::OP_STEP : bera_pkg::OP_START;
    in_item.center_x  = center_x;
    in_item.center_y  = center_y;
    in_item.x_half    = x_diameter[9:1];
    in_item.y_half    = y_diameter[9:1];
    in_item.pen_color = pen_color;
  end

  assign full    = (count == (PTR_W+1)'(bera_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bera_back.sv =====
// ----------------------------------------------------------------------------
// Ellipse rasterizer step engine
// Sets up the error terms, runs one iteration per step and emits pixels.
// ----------------------------------------------------------------------------
module bera_back #(
  parameter int WIDTH  = 800,
  parameter int HEIGHT = 600
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  bera_pkg::item_t      q_item,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [11:0]   pixel_x,
  output logic signed [11:0]   pixel_y,
  output logic [31:0]          pixel_color,
  output logic                 on_screen,
  output logic                 last,
  output logic                 done_res
);

  localparam int AW = bera_pkg::ACC_W;
  localparam int CW = bera_pkg::COORD_W;
  localparam logic [CW-2:0] W_LIM = (CW-1)'(WIDTH);
  localparam logic [CW-2:0] H_LIM = (CW-1)'(HEIGHT);

  bera_pkg::bstate_t bstate;
  bera_pkg::bstate_t bstate_next;
  bera_pkg::phase_t  phase;

  logic signed [CW-1:0] left_x;
  logic signed [CW-1:0] right_x;
  logic signed [CW-1:0] upper_y;
  logic signed [CW-1:0] lower_y;
  logic signed [AW-1:0] err_acc;
  logic signed [AW-1:0] x_increment;
  logic signed [AW-1:0] y_increment;
  logic [23:0]          a_scaled;
  logic [23:0]          b_scaled;
  logic [10:0]          height_span;
  logic [31:0]          held_color;

  logic [9:0]           a_hold;
  logic [19:0]          aa;
  logic [19:0]          bb;
  logic signed [CW-1:0] xs [4];
  logic signed [CW-1:0] sy0;
  logic signed [CW-1:0] sy1;
  logic [1:0]           ucnt;
  logic [1:0]           pcnt;
  logic                 upd_done;
  logic                 tip;
  logic                 fin;
  logic                 ystep;
  logic                 xcond;
  logic                 xstep;
  logic                 ovalid;

  logic [8:0]           hx;
  logic [8:0]           hy;
  logic [9:0]           a_val;
  logic [9:0]           b_val;
  logic signed [10:0]   om_a;
  logic signed [31:0]   xprod;
  logic signed [AW-1:0] e2;
  logic signed [13:0]   span_diff;
  logic signed [13:0]   span_lim;
  logic signed [CW-1:0] px_cur;
  logic signed [CW-1:0] py_cur;
  logic                 out_free;
  logic                 load_px;
  logic                 vis;

  assign hx        = q_item.x_half;
  assign hy        = q_item.y_half;
  assign a_val     = {hx, 1'b0};
  assign b_val     = {hy, 1'b0};
  assign om_a      = 11'sd1 - $signed({1'b0, a_hold});
  assign xprod     = 32'(om_a) * 32'($signed({1'b0, bb}));
  assign e2        = err_acc <<< 1;
  assign span_diff = $signed({{2{upper_y[CW-1]}}, upper_y})
                   - $signed({{2{lower_y[CW-1]}}, lower_y});
  assign span_lim  = $signed({3'b000, height_span});

  assign px_cur    = xs[pcnt];
  assign py_cur    = pcnt[1] ? sy1 : sy0;
  assign vis       = !px_cur[CW-1] && (px_cur[CW-2:0] < W_LIM)
                  && !py_cur[CW-1] && (py_cur[CW-2:0] < H_LIM);
  assign out_free  = !ovalid || pop;
  assign load_px   = (bstate == bera_pkg::BS_RUN) && out_free
                  && ((pcnt != 2'd3) || upd_done);
  assign empty     = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= bera_pkg::BS_IDLE;
    end else begin
      bstate <= bstate_next;
    end
  end

  always_comb begin
    bstate_next = bstate;
    q_pop       = 1'b0;
    case (bstate)
      bera_pkg::BS_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == bera_pkg::OP_START) begin
            bstate_next = bera_pkg::BS_SETUP1;
          end else if (phase != bera_pkg::PH_IDLE) begin
            bstate_next = bera_pkg::BS_RUN;
          end
        end
      end
      bera_pkg::BS_SETUP1: begin
        bstate_next = bera_pkg::BS_SETUP2;
      end
      bera_pkg::BS_SETUP2: begin
        bstate_next = bera_pkg::BS_IDLE;
      end
      bera_pkg::BS_RUN: begin
        if (load_px && (pcnt == 2'd3)) begin
          bstate_next = bera_pkg::BS_IDLE;
        end
      end
      default: begin
        bstate_next = bera_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= bera_pkg::PH_IDLE;
      ovalid   <= 1'b0;
      ucnt     <= '0;
      pcnt     <= '0;
      upd_done <= 1'b0;
    end else begin
      if (load_px) begin
        ovalid      <= 1'b1;
        pixel_x     <= px_cur;
        pixel_y     <= py_cur;
        pixel_color <= held_color;
        on_screen   <= vis;
        last        <= (pcnt == 2'd3);
        done_res    <= (pcnt == 2'd3) && fin;
        pcnt        <= pcnt + 1'b1;
      end else if (pop && ovalid) begin
        ovalid <= 1'b0;
      end
      case (bstate)
        bera_pkg::BS_IDLE: begin
          if (q_valid) begin
            if (q_item.op == bera_pkg::OP_START) begin
              left_x      <= $signed({2'b00, q_item.center_x}) - $signed({3'b000, hx});
              right_x     <= $signed({2'b00, q_item.center_x}) + $signed({3'b000, hx});
              upper_y     <= $signed({2'b00, q_item.center_y});
              lower_y     <= $signed({2'b00, q_item.center_y});
              height_span <= {1'b0, b_val};
              held_color  <= q_item.pen_color;
              a_hold      <= a_val;
              aa          <= {10'd0, a_val} * {10'd0, a_val};
              bb          <= {10'd0, b_val} * {10'd0, b_val};
            end else if (phase != bera_pkg::PH_IDLE) begin
              if (phase == bera_pkg::PH_TIP) begin
                xs[0] <= left_x - 12'sd1;
                xs[1] <= right_x + 12'sd1;
                xs[2] <= left_x - 12'sd1;
                xs[3] <= right_x + 12'sd1;
              end else begin
                xs[0] <= right_x;
                xs[1] <= left_x;
                xs[2] <= left_x;
                xs[3] <= right_x;
              end
              sy0      <= upper_y;
              sy1      <= lower_y;
              tip      <= (phase == bera_pkg::PH_TIP);
              fin      <= 1'b0;
              ucnt     <= '0;
              pcnt     <= '0;
              upd_done <= 1'b0;
            end
          end
        end
        bera_pkg::BS_SETUP1: begin
          x_increment <= {{(AW-34){xprod[31]}}, xprod, 2'b00};
          y_increment <= $signed({{(AW-22){1'b0}}, aa, 2'b00});
          a_scaled    <= {1'b0, aa, 3'b000};
          b_scaled    <= {1'b0, bb, 3'b000};
        end
        bera_pkg::BS_SETUP2: begin
          err_acc <= x_increment + y_increment;
          phase   <= bera_pkg::PH_LOOP;
        end
        bera_pkg::BS_RUN: begin
          if (!upd_done) begin
            if (tip) begin
              upper_y  <= upper_y + 12'sd1;
              lower_y  <= lower_y - 12'sd1;
              upd_done <= 1'b1;
              if (!((span_diff + 14'sd2) < span_lim)) begin
                fin   <= 1'b1;
                phase <= bera_pkg::PH_IDLE;
              end
            end else begin
              ucnt <= ucnt + 1'b1;
              case (ucnt)
                2'd0: begin
                  ystep <= (e2 <= y_increment);
                  xcond <= (e2 >= x_increment);
                  if (e2 <= y_increment) begin
                    upper_y     <= upper_y + 12'sd1;
                    lower_y     <= lower_y - 12'sd1;
                    y_increment <= y_increment + $signed({{(AW-24){1'b0}}, a_scaled});
                  end
                end
                2'd1: begin
                  if (ystep) begin
                    err_acc <= err_acc + y_increment;
                  end
                end
                2'd2: begin
                  xstep <= xcond || (e2 > y_increment);
                  if (xcond || (e2 > y_increment)) begin
                    left_x      <= left_x + 12'sd1;
                    right_x     <= right_x - 12'sd1;
                    x_increment <= x_increment + $signed({{(AW-24){1'b0}}, b_scaled});
                  end
                end
                2'd3: begin
                  upd_done <= 1'b1;
                  if (xstep) begin
                    err_acc <= err_acc + x_increment;
                  end
                  if (left_x > right_x) begin
                    if (span_diff < span_lim) begin
                      phase <= bera_pkg::PH_TIP;
                    end else begin
                      phase <= bera_pkg::PH_IDLE;
                      fin   <= 1'b1;
                    end
                  end
                end
                default: begin
                  upd_done <= 1'b1;
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/bresenham_ellipse_raster_core.sv =====
// ----------------------------------------------------------------------------
// Bresenham ellipse rasterizer
// Walks an integer midpoint ellipse and streams its quadrant pixels.
// ----------------------------------------------------------------------------
// Commands enter through a queue port: a beat is taken when push is high and
// full is low. A start command loads center, diameters and color and emits
// nothing; a step command runs one iteration and emits four pixel beats, with
// last on the fourth and done_res on the final pixel of the ellipse. A step
// with no ellipse in progress is dropped.
// Pixels leave through a queue port: the current beat is valid while empty is
// low and is taken when pop is high.
// A two-entry command queue decouples intake from the step engine. A start
// passes through the setup states SETUP1 and SETUP2 for the setup multiplies
// and the error-term sum. A main-loop step is fetched from the queue, runs the
// dependent error update and then emits the final pixel; the first three
// pixels go out while the update runs. A tip step has a shorter update. The
// first pixel of a step is loaded into the output register in the run state.
// A stalled receiver holds the output register and the engine waits, and the
// command queue fills and raises full.
// Synchronous reset empties both queues and returns the engine to idle.
// ----------------------------------------------------------------------------
module bresenham_ellipse_raster_core #(
  parameter int WIDTH  = 800,
  parameter int HEIGHT = 600
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                cmd,
  input  logic [9:0]          center_x,
  input  logic [9:0]          center_y,
  input  logic [9:0]          x_diameter,
  input  logic [9:0]          y_diameter,
  input  logic [31:0]         pen_color,
  output logic                empty,
  input  logic                pop,
  output logic signed [11:0]  pixel_x,
  output logic signed [11:0]  pixel_y,
  output logic [31:0]         pixel_color,
  output logic                on_screen,
  output logic                last,
  output logic                done_res
);

  logic            q_valid;
  logic            q_pop;
  bera_pkg::item_t q_item;

  bera_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .center_x   (center_x),
    .center_y   (center_y),
    .x_diameter (x_diameter),
    .y_diameter (y_diameter),
    .pen_color  (pen_color),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  bera_back #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .on_screen   (on_screen),
    .last        (last),
    .done_res    (done_res)
  );

endmodule

// ===== rtl/bera_checker.sv =====
// ----------------------------------------------------------------------------
// Ellipse rasterizer port checker
// Checks the pixel stream seen on the ports of the rasterizer.
// ----------------------------------------------------------------------------
`include "bresenham_ellipse_raster_core_assert.svh"

module bera_checker #(
  parameter int WIDTH  = 800,
  parameter int HEIGHT = 600
) (
  input logic               clk,
  input logic               rst,
  input logic               pop,
  input logic               empty,
  input logic signed [11:0] pixel_x,
  input logic signed [11:0] pixel_y,
  input logic               on_screen,
  input logic               last,
  input logic               done_res
);

  localparam logic [10:0] W_LIM = 11'(WIDTH);
  localparam logic [10:0] H_LIM = 11'(HEIGHT);

  `BERA_ASSERT_NXT(a_hold_stalled, !empty && !pop, !empty && $stable(pixel_x) && $stable(pixel_y) && $stable(done_res))
  `BERA_ASSERT_IMP(a_done_is_last, !empty && done_res, last)
  `BERA_ASSERT_IMP(a_on_inside, !empty && on_screen, !pixel_x[11] && (pixel_x[10:0] < W_LIM) && !pixel_y[11] && (pixel_y[10:0] < H_LIM))
  `BERA_ASSERT_IMP(a_off_outside, !empty && !on_screen, pixel_x[11] || (pixel_x[10:0] >= W_LIM) || pixel_y[11] || (pixel_y[10:0] >= H_LIM))

endmodule

bind bresenham_ellipse_raster_core bera_checker #(
  .WIDTH  (WIDTH),
  .HEIGHT (HEIGHT)
) u_bera_checker (.*);

// ===== test/bresenham_ellipse_raster_core_tb.sv =====
// ----------------------------------------------------------------------------
// Ellipse rasterizer testbench
// Drives start and step commands into the rasterizer and checks every pixel
// beat against a cycle-free model of the midpoint ellipse walk. A short table
// covers the corners of the geometry, the line and tip cases and abandoned
// ellipses. Random ellipses, mostly small ones, follow under several idle and
// stall patterns, including one long receiver hold that fills the block.
// ----------------------------------------------------------------------------
module bresenham_ellipse_raster_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH        = 800;
  localparam int HEIGHT       = 600;
  localparam int RANDOM_ITEMS = 336;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_MAX = 2000;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [31:0]        color;
    logic               vis;
    logic               lst;
    logic               dn;
  } pixel_t;

  typedef struct packed {
    bera_pkg::op_t      op;
    logic [9:0]         cx;
    logic [9:0]         cy;
    logic [9:0]         xd;
    logic [9:0]         yd;
    logic [31:0]        color;
    logic               typed;
    logic signed [11:0] tx;
    logic signed [11:0] ty;
  } stim_row_t;

  localparam stim_row_t DIRECTED [25] = '{
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_START, 10'd0, 10'd0, 10'd1023, 10'd1023, 32'hFFFF_FFFF,
      1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b1, 12'sd511, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd1023, 10'd1023, 10'd1023, 10'd1023, 32'hFFFF_FFFF,
      1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_START, 10'd1023, 10'd1023, 10'd1022, 10'd1022, 32'h0,
      1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b1, 12'sd1534, 12'sd1023},
    '{bera_pkg::OP_START, 10'd400, 10'd300, 10'd0, 10'd6, 32'hA5A5_A5A5,
      1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b1, 12'sd400, 12'sd300},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_START, 10'd400, 10'd300, 10'd1, 10'd9, 32'h5A5A_5A5A,
      1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b1, 12'sd400, 12'sd300},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_START, 10'd5, 10'd599, 10'd7, 10'd1, 32'h1234_5678,
      1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b1, 12'sd8, 12'sd599},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_START, 10'd300, 10'd200, 10'd4, 10'd4, 32'h0F0F_0F0F,
      1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b1, 12'sd302, 12'sd200},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0},
    '{bera_pkg::OP_STEP,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0, 1'b0, 12'sd0, 12'sd0}
  };

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic               cmd;
  logic [9:0]         center_x;
  logic [9:0]         center_y;
  logic [9:0]         x_diameter;
  logic [9:0]         y_diameter;
  logic [31:0]        pen_color;
  logic               empty;
  logic               pop;
  logic signed [11:0] pixel_x;
  logic signed [11:0] pixel_y;
  logic [31:0]        pixel_color;
  logic               on_screen;
  logic               last;
  logic               done_res;

  int     send_gap_pct;
  int     recv_stall_pct;
  logic   hold_request;
  int     errors;
  int     quiet_cycles;

  pixel_t pending_pixels[$];
  pixel_t fresh_pixels[4];
  int     fresh_count;

  bera_pkg::phase_t trace_phase;
  int               col_lo;
  int               col_hi;
  int               row_up;
  int               row_dn;
  int               row_span;
  longint           err_sum;
  longint           step_x;
  longint           step_y;
  longint           grow_a;
  longint           grow_b;
  logic [31:0]      ink;

  bresenham_ellipse_raster_core #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .center_x   (center_x),
    .center_y   (center_y),
    .x_diameter (x_diameter),
    .y_diameter (y_diameter),
    .pen_color  (pen_color),
    .empty      (empty),
    .pop        (pop),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_color(pixel_color),
    .on_screen  (on_screen),
    .last       (last),
    .done_res   (done_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pixel_t make_pixel(int px, int py, logic lst, logic dn);
    pixel_t p;
    p.x     = px[11:0];
    p.y     = py[11:0];
    p.color = ink;
    p.vis   = (px >= 0) && (px < WIDTH) && (py >= 0) && (py < HEIGHT);
    p.lst   = lst;
    p.dn    = dn;
    return p;
  endfunction

  task automatic trace_item(input bera_pkg::op_t op, input logic [9:0] cx,
                            input logic [9:0] cy, input logic [9:0] xd,
                            input logic [9:0] yd, input logic [31:0] color);
    int     half_x;
    int     half_y;
    int     x0;
    int     x1;
    int     y0;
    int     y1;
    longint a;
    longint b;
    longint e2;
    logic   fin;
    fresh_count = 0;
    fin = 1'b0;
    if (op == bera_pkg::OP_START) begin
      half_x      = int'(xd >> 1);
      half_y      = int'(yd >> 1);
      a           = 2 * half_x;
      b           = 2 * half_y;
      col_lo      = int'(cx) - half_x;
      col_hi      = int'(cx) + half_x;
      row_up      = int'(cy);
      row_dn      = int'(cy);
      step_x      = 4 * (1 - a) * b * b;
      step_y      = 4 * a * a;
      err_sum     = step_x + step_y;
      grow_a      = 8 * a * a;
      grow_b      = 8 * b * b;
      row_span    = int'(b);
      ink         = color;
      trace_phase = bera_pkg::PH_LOOP;
    end else if (trace_phase == bera_pkg::PH_LOOP) begin
      e2 = 2 * err_sum;
      x0 = col_lo;
      x1 = col_hi;
      y0 = row_up;
      y1 = row_dn;
      if (e2 <= step_y) begin
        row_up++;
        row_dn--;
        step_y  += grow_a;
        err_sum += step_y;
      end
      if (e2 >= step_x || 2 * err_sum > step_y) begin
        col_lo++;
        col_hi--;
        step_x  += grow_b;
        err_sum += step_x;
      end
      if (col_lo > col_hi) begin
        if (row_up - row_dn < row_span) begin
          trace_phase = bera_pkg::PH_TIP;
        end else begin
          trace_phase = bera_pkg::PH_IDLE;
          fin = 1'b1;
        end
      end
      fresh_pixels[0] = make_pixel(x1, y0, 1'b0, 1'b0);
      fresh_pixels[1] = make_pixel(x0, y0, 1'b0, 1'b0);
      fresh_pixels[2] = make_pixel(x0, y1, 1'b0, 1'b0);
      fresh_pixels[3] = make_pixel(x1, y1, 1'b1, fin);
      fresh_count = 4;
    end else if (trace_phase == bera_pkg::PH_TIP) begin
      x0 = col_lo - 1;
      x1 = col_hi + 1;
      y0 = row_up;
      y1 = row_dn;
      row_up++;
      row_dn--;
      fin = !(row_up - row_dn < row_span);
      if (fin) begin
        trace_phase = bera_pkg::PH_IDLE;
      end
      fresh_pixels[0] = make_pixel(x0, y0, 1'b0, 1'b0);
      fresh_pixels[1] = make_pixel(x1, y0, 1'b0, 1'b0);
      fresh_pixels[2] = make_pixel(x0, y1, 1'b0, 1'b0);
      fresh_pixels[3] = make_pixel(x1, y1, 1'b1, fin);
      fresh_count = 4;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(input bera_pkg::op_t op, input logic [9:0] cx,
                           input logic [9:0] cy, input logic [9:0] xd,
                           input logic [9:0] yd, input logic [31:0] color,
                           input logic typed, input logic signed [11:0] tx,
                           input logic signed [11:0] ty);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push       = 1'b1;
    cmd        = op;
    center_x   = cx;
    center_y   = cy;
    x_diameter = xd;
    y_diameter = yd;
    pen_color  = color;
    do @(posedge clk); while (full);
    trace_item(op, cx, cy, xd, yd, color);
    if (typed && fresh_count > 0) begin
      fresh_pixels[0].x = tx;
      fresh_pixels[0].y = ty;
    end
    for (int k = 0; k < fresh_count; k++) begin
      pending_pixels.push_back(fresh_pixels[k]);
    end
    @(negedge clk);
  endtask

  function automatic logic [9:0] pick_diameter();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      return 10'($urandom_range(0, 24));
    end else if (roll < 97) begin
      return 10'($urandom_range(0, 160));
    end
    return 10'($urandom_range(0, 1023));
  endfunction

  initial begin : stimulus
    int            counted;
    bera_pkg::op_t op;
    logic          idle_step;
    trace_phase    = bera_pkg::PH_IDLE;
    col_lo         = 0;
    col_hi         = 0;
    row_up         = 0;
    row_dn         = 0;
    row_span       = 0;
    err_sum        = 0;
    step_x         = 0;
    step_y         = 0;
    grow_a         = 0;
    grow_b         = 0;
    ink            = '0;
    errors         = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    rst            = 1'b1;
    push           = 1'b0;
    cmd            = bera_pkg::OP_START;
    center_x       = '0;
    center_y       = '0;
    x_diameter     = '0;
    y_diameter     = '0;
    pen_color      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].op, DIRECTED[i].cx, DIRECTED[i].cy, DIRECTED[i].xd,
                DIRECTED[i].yd, DIRECTED[i].color, DIRECTED[i].typed,
                DIRECTED[i].tx, DIRECTED[i].ty);
    end

    hold_request = 1'b1;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      case (counted / (RANDOM_ITEMS / 4))
        0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_gap_pct = 58; recv_stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct = 58; end
        default: begin send_gap_pct = 11; recv_stall_pct = 11; end
      endcase
      if (trace_phase == bera_pkg::PH_IDLE) begin
        op = ($urandom_range(0, 9) == 0) ? bera_pkg::OP_STEP : bera_pkg::OP_START;
      end else begin
        op = ($urandom_range(0, 49) == 0) ? bera_pkg::OP_START : bera_pkg::OP_STEP;
      end
      idle_step = (op == bera_pkg::OP_STEP) && (trace_phase == bera_pkg::PH_IDLE);
      send_item(op, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                pick_diameter(), pick_diameter(), 32'($urandom), 1'b0, 12'sd0, 12'sd0);
      if (!idle_step) begin
        counted++;
      end
    end

    push = 1'b0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("bresenham_ellipse_raster_core_tb passed");
    end else begin
      $display("bresenham_ellipse_raster_core_tb failed");
    end
    $finish;
  end

  initial begin : receiver
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      pop = ($urandom_range(0, 99) >= recv_stall_pct);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel beat with nothing expected: x %0d y %0d", pixel_x, pixel_y);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_x !== want.x) begin
          $error("pixel_x expected %0d got %0d", want.x, pixel_x);
          errors++;
        end
        if (pixel_y !== want.y) begin
          $error("pixel_y expected %0d got %0d", want.y, pixel_y);
          errors++;
        end
        if (pixel_color !== want.color) begin
          $error("pixel_color expected %h got %h", want.color, pixel_color);
          errors++;
        end
        if (on_screen !== want.vis) begin
          $error("on_screen expected %0b got %0b", want.vis, on_screen);
          errors++;
        end
        if (last !== want.lst) begin
          $error("last expected %0b got %0b", want.lst, last);
          errors++;
        end
        if (done_res !== want.dn) begin
          $error("done_res expected %0b got %0b", want.dn, done_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("bresenham_ellipse_raster_core_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
